// ===== rtl/core/checksummed_frame_deframer_core_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef CHECKSUMMED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define CHECKSUMMED_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define CFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

    localparam int LEN_W = 16;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    typedef enum logic [1:0] {
        STATUS_GOOD = 2'd0,
        STATUS_BAD  = 2'd1,
        STATUS_LONG = 2'd2
    } frame_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfd_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfd_apb_regs (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output logic      [cfd_pkg::LEN_W-1:0] max_payload_length
);
    import cfd_pkg::*;

    // Register index 0 sits at byte address 0; paddr[2] carries the index.
    localparam logic REG_MAX_LEN = 1'b0;

    logic [LEN_W-1:0] max_len_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= {LEN_W{1'b1}};
        end else if (wr_en) begin
            max_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = 32'h0;
        if (paddr[2] == REG_MAX_LEN) begin
            prdata = {{(32-LEN_W){1'b0}}, max_len_reg};
        end
    end

    assign max_payload_length = max_len_reg;

endmodule

`default_nettype wire

// ===== rtl/core/checksummed_frame_deframer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_rx_byte[7:0]
//  m_        out        m_valid/m_ready    m_payload_byte[7:0], m_payload_valid,
//                                          m_frame_end, m_frame_status[1:0]
//  APB       in         psel/penable       paddr[2:0], pwdata/prdata[31:0]
//
//  One byte per cycle while s_ready is high; a result appears on m_ in the cycle after the byte that causes it.
//  The frame phase, length, count and sum update in the cycle a byte is taken.
//  A single output register holds a result; s_ready is low only while it is full
//  and m_ready is low.
//  aresetn is synchronous and active low; it returns the block to hunting and
//  sets max_payload_length to 65535.

`include "checksummed_frame_deframer_core_defines.svh"

module checksummed_frame_deframer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_payload_byte,
    output logic             m_payload_valid,
    output logic             m_frame_end,
    output logic      [1:0]  m_frame_status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import cfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4
    } phase_t;

    logic [LEN_W-1:0] max_len;

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] seen_reg, seen_next;
    logic [7:0]       sum_reg, sum_next;

    logic             m_valid_reg;
    logic [7:0]       m_payload_byte_reg;
    logic             m_payload_valid_reg;
    logic             m_frame_end_reg;
    frame_status_t    m_frame_status_reg;

    logic             accept;
    logic             res_valid;
    logic [7:0]       res_byte;
    logic             res_pvalid;
    logic             res_end;
    frame_status_t    res_status;
    logic [LEN_W-1:0] full_len;
    logic [LEN_W-1:0] seen_inc;
    logic [7:0]       sum_add;

    cfd_apb_regs u_regs (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .max_payload_length (max_len)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    assign full_len = {len_reg[LEN_W-1:8], s_rx_byte};
    assign seen_inc = seen_reg + {{(LEN_W-1){1'b0}}, 1'b1};
    assign sum_add  = sum_reg + s_rx_byte;

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        sum_next   = sum_reg;
        res_valid  = 1'b0;
        res_byte   = 8'h00;
        res_pvalid = 1'b0;
        res_end    = 1'b0;
        res_status = STATUS_GOOD;
        case (phase_reg)
            PH_LEN_HI: begin
                len_next   = {s_rx_byte, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seen_next = '0;
                sum_next  = 8'h00;
                if (full_len > max_len) begin
                    // too long: close now and go back to hunting
                    phase_next = PH_HUNT;
                    len_next   = '0;
                    res_valid  = 1'b1;
                    res_end    = 1'b1;
                    res_status = STATUS_LONG;
                end else begin
                    len_next   = full_len;
                    phase_next = (full_len == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                sum_next   = sum_add;
                seen_next  = seen_inc;
                if (seen_inc >= len_reg) begin
                    phase_next = PH_CHECK;
                end
                res_valid  = 1'b1;
                res_byte   = s_rx_byte;
                res_pvalid = 1'b1;
            end
            PH_CHECK: begin
                phase_next = PH_HUNT;
                len_next   = '0;
                seen_next  = '0;
                sum_next   = 8'h00;
                res_valid  = 1'b1;
                res_end    = 1'b1;
                res_status = (sum_add == SUM_GOOD) ? STATUS_GOOD : STATUS_BAD;
            end
            default: begin
                phase_next = (s_rx_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
                len_next   = '0;
                seen_next  = '0;
                sum_next   = 8'h00;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            len_reg     <= '0;
            seen_reg    <= '0;
            sum_reg     <= 8'h00;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                seen_reg  <= seen_next;
                sum_reg   <= sum_next;
            end
            if (accept && res_valid) begin
                m_valid_reg         <= 1'b1;
                m_payload_byte_reg  <= res_byte;
                m_payload_valid_reg <= res_pvalid;
                m_frame_end_reg     <= res_end;
                m_frame_status_reg  <= res_status;
            end else if (m_ready) begin
                // drop the word once taken
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_byte  = m_payload_byte_reg;
    assign m_payload_valid = m_payload_valid_reg;
    assign m_frame_end     = m_frame_end_reg;
    assign m_frame_status  = m_frame_status_reg;

    `CFD_ASSERT_NOW(a_data_not_end, m_valid_reg && m_payload_valid_reg,
        !m_frame_end_reg, "payload word also marks frame end")
    `CFD_ASSERT_NOW(a_status_only_at_end, m_valid_reg && !m_frame_end_reg,
        m_frame_status_reg == STATUS_GOOD, "status set on a word that is not frame end")
    `CFD_ASSERT_NEXT(a_data_emits, accept && (phase_reg == PH_DATA),
        m_valid_reg && m_payload_valid_reg, "payload byte taken but no word out")
    `CFD_ASSERT_NOW(a_count_in_range, phase_reg == PH_DATA,
        seen_reg < len_reg, "payload count reached length while still in data")

endmodule

`default_nettype wire

// ===== verif/tb_checksummed_frame_deframer_core.sv =====
`timescale 1ns / 1ps

module tb_checksummed_frame_deframer_core;
    import cfd_pkg::*;

    localparam logic [2:0] REG_MAX_PAYLOAD_LEN = 3'd0;

    typedef enum logic [2:0] {
        HUNTING,
        LENGTH_HIGH,
        LENGTH_LOW,
        PAYLOAD,
        CHECKSUM
    } rx_phase_t;

    typedef struct packed {
        logic [7:0]    data;
        logic          data_valid;
        logic          frame_end;
        frame_status_t status;
    } deframe_word_t;

    typedef struct {
        logic [7:0]    rx;
        bit            typed;
        deframe_word_t want;
    } directed_row_t;

    localparam deframe_word_t NO_WORD   = '{8'h00, 1'b0, 1'b0, STATUS_GOOD};
    localparam deframe_word_t GOOD_END  = '{8'h00, 1'b0, 1'b1, STATUS_GOOD};
    localparam deframe_word_t BAD_END   = '{8'h00, 1'b0, 1'b1, STATUS_BAD};
    localparam deframe_word_t ZERO_DATA = '{8'h00, 1'b1, 1'b0, STATUS_GOOD};

    // Frames at the reset limit: start byte as data, zero length, bad sums.
    directed_row_t directed_rows [21] = '{
        '{8'h00, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{START_BYTE, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h02, 1'b0, NO_WORD},
        '{START_BYTE, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h82, 1'b1, GOOD_END},
        '{START_BYTE, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'hFF, 1'b1, GOOD_END},
        '{START_BYTE, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b1, BAD_END},
        '{START_BYTE, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h01, 1'b0, NO_WORD},
        '{8'h00, 1'b1, ZERO_DATA},
        '{8'h00, 1'b1, BAD_END}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_payload_byte;
    logic        m_payload_valid;
    logic        m_frame_end;
    logic [1:0]  m_frame_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // deframer state as the block should hold it
    rx_phase_t   rx_phase = HUNTING;
    logic [15:0] declared_len = 16'd0;
    logic [15:0] data_count = 16'd0;
    logic [7:0]  data_sum = 8'd0;
    logic [15:0] max_len_cfg = 16'hFFFF;

    deframe_word_t expected_words [$];
    int          mismatch_count = 0;
    int          framed_bytes = 0;
    bit          steady_flow = 1'b0;

    checksummed_frame_deframer_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_payload_valid (m_payload_valid),
        .m_frame_end     (m_frame_end),
        .m_frame_status  (m_frame_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(0, 99) >= 30);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void return_to_hunt();
        rx_phase = HUNTING;
        declared_len = 16'd0;
        data_count = 16'd0;
        data_sum = 8'd0;
    endfunction

    // Advance the deframer state by one byte; returns 1 when a word comes out.
    function automatic bit deframe_byte(input logic [7:0] b, output deframe_word_t word);
        logic [7:0] check_sum;
        word = NO_WORD;
        case (rx_phase)
            LENGTH_HIGH: begin
                declared_len = {b, 8'h00};
                rx_phase = LENGTH_LOW;
                return 1'b0;
            end
            LENGTH_LOW: begin
                declared_len[7:0] = b;
                data_count = 16'd0;
                data_sum = 8'd0;
                if (declared_len > max_len_cfg) begin
                    return_to_hunt();
                    word.frame_end = 1'b1;
                    word.status = STATUS_LONG;
                    return 1'b1;
                end
                rx_phase = (declared_len == 16'd0) ? CHECKSUM : PAYLOAD;
                return 1'b0;
            end
            PAYLOAD: begin
                data_sum = data_sum + b;
                data_count = data_count + 16'd1;
                if (data_count >= declared_len)
                    rx_phase = CHECKSUM;
                word.data = b;
                word.data_valid = 1'b1;
                return 1'b1;
            end
            CHECKSUM: begin
                check_sum = data_sum + b;
                return_to_hunt();
                word.frame_end = 1'b1;
                word.status = (check_sum == SUM_GOOD) ? STATUS_GOOD : STATUS_BAD;
                return 1'b1;
            end
            default: begin
                return_to_hunt();
                if (b == START_BYTE)
                    rx_phase = LENGTH_HIGH;
                return 1'b0;
            end
        endcase
    endfunction

    // Present one byte, hold it until taken, then queue what it should cause.
    task automatic send_byte(input logic [7:0] b, input bit typed, input deframe_word_t want);
        deframe_word_t word;
        bit            has_word;
        if (!steady_flow) begin
            while ($urandom_range(0, 99) < 30) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (rx_phase != HUNTING || b == START_BYTE)
            framed_bytes++;
        has_word = deframe_byte(b, word);
        if (typed) begin
            has_word = 1'b1;
            word = want;
        end
        if (has_word)
            expected_words = {expected_words, word};
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the limit, then read it back.
    task automatic set_max_len(input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_MAX_PAYLOAD_LEN;
        pwdata <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        max_len_cfg = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[15:0] !== value)
            report_mismatch("max_payload_length readback", prdata[15:0], value);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_frame();
        int         len;
        int         n_send;
        int         pick;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] check;
        sum = 8'd0;
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
        send_byte(START_BYTE, 1'b0, NO_WORD);
        pick = $urandom_range(0, 99);
        if (pick < 10 && max_len_cfg < 300)
            len = max_len_cfg + $urandom_range(0, 1);
        else if (pick < 75)
            len = $urandom_range(0, 12);
        else if (pick < 92)
            len = $urandom_range(13, 300);
        else
            len = $urandom_range(0, 65535);
        if (len > 300 && len <= max_len_cfg)
            len = len % 301;
        send_byte(len[15:8], 1'b0, NO_WORD);
        send_byte(len[7:0], 1'b0, NO_WORD);
        if (len > max_len_cfg) begin
            // rest of an oversized frame is dropped while hunting
            repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
            return;
        end
        n_send = ($urandom_range(0, 99) < 3) ? $urandom_range(0, len) : len;
        for (int i = 0; i < n_send; i++) begin
            b = ($urandom_range(0, 9) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b, 1'b0, NO_WORD);
        end
        if (n_send != len)
            return;
        check = SUM_GOOD - sum;
        if ($urandom_range(0, 99) < 20)
            check = check ^ 8'($urandom_range(1, 255));
        send_byte(check, 1'b0, NO_WORD);
    endtask

    always @(posedge aclk) begin
        deframe_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word, payload_byte", m_payload_byte, 0);
            end else begin
                want = expected_words.pop_front();
                if (m_payload_byte !== want.data)
                    report_mismatch("payload_byte", m_payload_byte, want.data);
                if (m_payload_valid !== want.data_valid)
                    report_mismatch("payload_valid", m_payload_valid, want.data_valid);
                if (m_frame_end !== want.frame_end)
                    report_mismatch("frame_end", m_frame_end, want.frame_end);
                if (m_frame_status !== want.status)
                    report_mismatch("frame_status", m_frame_status, want.status);
            end
        end
    end

    initial begin
        logic [15:0] max_len_plan [6];
        int          phase_target;
        max_len_plan = '{16'd0, 16'd1, 16'd8, 16'd0, 16'd300, 16'hFFFF};
        max_len_plan[3] = 16'($urandom_range(0, 65535));
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 21; i++)
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();
        for (int p = 0; p < 6; p++) begin
            set_max_len(max_len_plan[p]);
            steady_flow = (p == 2);
            phase_target = framed_bytes + 90;
            while (framed_bytes < phase_target)
                send_random_frame();
            // finish any cut-short frame before touching the limit
            while (rx_phase != HUNTING)
                send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
            wait_drained();
            steady_flow = 1'b0;
        end
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
